[rtl/core/serial_loaded_bank_mapper_defines.svh]
// ----------------------------------------------------------------------------
// serial loaded bank mapper assertion macros
// shared concurrent assertion forms for the mapper modules
// ----------------------------------------------------------------------------
`ifndef SERIAL_LOADED_BANK_MAPPER_DEFINES_SVH
`define SERIAL_LOADED_BANK_MAPPER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SLBM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SLBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/slbm_pkg.sv]
// ----------------------------------------------------------------------------
// slbm_pkg
// types and fixed codes shared by the bank mapper modules
// ----------------------------------------------------------------------------
package slbm_pkg;

   // item operations
   localparam logic [1:0] OP_CPU_WRITE  = 2'd0;
   localparam logic [1:0] OP_CPU_LOOKUP = 2'd1;
   localparam logic [1:0] OP_PPU_LOOKUP = 2'd2;

   // lookup targets
   localparam logic [2:0] TGT_NONE    = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM = 3'd1;
   localparam logic [2:0] TGT_PRG_RAM = 3'd2;
   localparam logic [2:0] TGT_CHR_ROM = 3'd3;
   localparam logic [2:0] TGT_CHR_RAM = 3'd4;

   // csr indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_BANK_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_BANK_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_RAM_PRESENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_MIRROR  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_STEP      = 3'd4;

   // serial register select, address bits 15..13
   localparam logic [2:0] SEL_CONTROL  = 3'b100;
   localparam logic [2:0] SEL_CHR_LOW  = 3'b101;
   localparam logic [2:0] SEL_CHR_HIGH = 3'b110;
   localparam logic [2:0] SEL_PRG_BANK = 3'b111;

   // control bits forced by a reset write
   localparam logic [4:0] CONTROL_FORCE = 5'h0C;

   // remainder unit: one dividend bit per step
   localparam int                   DIV_CNT_W = 3;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [31:0] cycle;
   } req_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [17:0] target_offset;
      logic        writable;
      logic [1:0]  nt_mirror;
      logic        write_ignored;
      logic        write_through;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic div_load;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

[rtl/core/slbm_ctrl.sv]
// ----------------------------------------------------------------------------
// slbm_ctrl
// sequencer: accept, operand prep, remainder steps, state update
// ----------------------------------------------------------------------------
`include "serial_loaded_bank_mapper_defines.svh"

module slbm_ctrl
   import slbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PREP   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_PREP;
         end
         ST_PREP:   state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign cmd.load_item = start && (state_ff == ST_IDLE);
   assign cmd.div_load  = (state_ff == ST_PREP);
   assign cmd.div_step  = (state_ff == ST_DIV) && !status.div_done;
   assign cmd.finish    = (state_ff == ST_FINISH);

   `SLBM_ASSERT_SAME(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd), "overlapping commands")
   `SLBM_ASSERT_NEXT(a_accept_to_prep, clock, reset, start && !busy, state_ff == ST_PREP,
      "accepted item did not enter prep")
   `SLBM_ASSERT_NEXT(a_finish_frees, clock, reset, cmd.finish, !busy,
      "block still busy after finish")

endmodule

[rtl/core/slbm_dpath.sv]
// ----------------------------------------------------------------------------
// slbm_dpath
// mapper registers, bank select, remainder unit and result register
// ----------------------------------------------------------------------------
`include "serial_loaded_bank_mapper_defines.svh"

module slbm_dpath
   import slbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  req_type                req_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_payload
);

   // latched item
   req_type item_ff;

   // csr
   logic [4:0] prg_count_ff;
   logic [5:0] chr_count_ff;
   logic       chr_ram_ff;
   logic [7:0] step_ff;

   // mapper state
   logic [4:0]  shift_bits_ff,  shift_bits_in;
   logic [2:0]  shift_count_ff, shift_count_in;
   logic [4:0]  control_ff,     control_in;
   logic [1:0]  prg_mode_ff,    prg_mode_in;
   logic        chr_mode_ff,    chr_mode_in;
   logic [4:0]  chr_low_ff,     chr_low_in;
   logic [4:0]  chr_high_ff,    chr_high_in;
   logic [3:0]  prg_bank_ff,    prg_bank_in;
   logic [1:0]  mirror_ff,      mirror_in;
   logic [31:0] last_cycle_ff,  last_cycle_in;
   logic [1:0]  mirror_fin;

   // remainder unit
   logic [4:0]           div_num_ff,  div_num_in;
   logic [5:0]           div_rem_ff,  div_rem_in;
   logic [5:0]           div_den_ff;
   logic [4:0]           div_raw_ff;
   logic                 div_bypass_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [6:0]           div_trial;
   logic [4:0]           wrapped;

   // operand select
   logic [4:0] shift_next;
   logic [4:0] prg_pre;
   logic [4:0] chr_pre;
   logic [4:0] opnd_num;
   logic [5:0] opnd_den;
   logic [4:0] commit_val;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_payload;
   end

   // ---------------- operand prep ----------------
   assign shift_next = {item_ff.data[0], shift_bits_ff[4:1]};

   always_comb begin
      prg_pre = 5'd0;
      case (prg_mode_ff)
         2'd0, 2'd1: begin
            prg_pre = item_ff.addr[14] ? {1'b0, prg_bank_ff[3:1], 1'b1}
                                       : {1'b0, prg_bank_ff[3:1], 1'b0};
         end
         2'd2: begin
            prg_pre = item_ff.addr[14] ? {1'b0, prg_bank_ff} : 5'd0;
         end
         default: begin
            // fixed last bank in the upper window
            if (!item_ff.addr[14]) prg_pre = {1'b0, prg_bank_ff};
            else if (prg_count_ff != 5'd0) prg_pre = prg_count_ff - 5'd1;
            else prg_pre = 5'd0;
         end
      endcase
   end

   always_comb begin
      if (!chr_mode_ff) begin
         chr_pre = item_ff.addr[12] ? {chr_low_ff[4:1], 1'b1} : {chr_low_ff[4:1], 1'b0};
      end else begin
         chr_pre = item_ff.addr[12] ? chr_high_ff : chr_low_ff;
      end
   end

   always_comb begin
      case (item_ff.op)
         OP_CPU_LOOKUP: begin
            opnd_num = prg_pre;
            opnd_den = {1'b0, prg_count_ff};
         end
         OP_PPU_LOOKUP: begin
            opnd_num = chr_pre;
            opnd_den = chr_count_ff;
         end
         default: begin
            opnd_num = shift_next;
            opnd_den = chr_count_ff;
         end
      endcase
   end

   // ---------------- remainder unit ----------------
   assign div_trial = ({div_rem_ff, div_num_ff[4]} >= {1'b0, div_den_ff})
                    ? ({div_rem_ff, div_num_ff[4]} - {1'b0, div_den_ff})
                    : {div_rem_ff, div_num_ff[4]};
   assign div_rem_in = div_trial[5:0];
   assign div_num_in = {div_num_ff[3:0], 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_num_ff    <= opnd_num;
         div_raw_ff    <= opnd_num;
         div_den_ff    <= opnd_den;
         div_bypass_ff <= (opnd_den == 6'd0);
         div_rem_ff    <= 6'd0;
         div_cnt_ff    <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   assign status.div_done = (div_cnt_ff == DIV_STEPS);
   // zero count skips the wrap
   assign wrapped = div_bypass_ff ? div_raw_ff : div_rem_ff[4:0];

   // ---------------- item effect ----------------
   always_comb begin
      shift_bits_in  = shift_bits_ff;
      shift_count_in = shift_count_ff;
      control_in     = control_ff;
      prg_mode_in    = prg_mode_ff;
      chr_mode_in    = chr_mode_ff;
      chr_low_in     = chr_low_ff;
      chr_high_in    = chr_high_ff;
      prg_bank_in    = prg_bank_ff;
      mirror_fin     = mirror_ff;
      last_cycle_in  = last_cycle_ff;
      commit_val     = control_ff | CONTROL_FORCE;

      rsp_in               = '0;
      rsp_in.target        = TGT_NONE;
      rsp_in.write_through = 1'b1;

      case (item_ff.op)
         OP_CPU_WRITE: begin
            if (item_ff.addr[15]) begin
               last_cycle_in = item_ff.cycle;
               if (item_ff.data[7]) begin
                  control_in     = commit_val;
                  mirror_fin     = commit_val[1:0];
                  prg_mode_in    = commit_val[3:2];
                  chr_mode_in    = commit_val[4];
                  shift_bits_in  = 5'd0;
                  shift_count_in = 3'd0;
               end else if (item_ff.cycle == last_cycle_ff + {24'd0, step_ff}) begin
                  rsp_in.write_ignored = 1'b1;
               end else if (shift_count_ff == 3'd4) begin
                  // fifth bit commits
                  shift_bits_in  = 5'd0;
                  shift_count_in = 3'd0;
                  case (item_ff.addr[15:13])
                     SEL_CONTROL: begin
                        control_in  = shift_next;
                        mirror_fin  = shift_next[1:0];
                        prg_mode_in = shift_next[3:2];
                        chr_mode_in = shift_next[4];
                     end
                     SEL_CHR_LOW:  chr_low_in  = wrapped;
                     SEL_CHR_HIGH: chr_high_in = wrapped;
                     SEL_PRG_BANK: prg_bank_in = shift_next[3:0];
                     default: ;
                  endcase
               end else begin
                  shift_bits_in  = shift_next;
                  shift_count_in = shift_count_ff + 3'd1;
               end
            end
         end
         OP_CPU_LOOKUP: begin
            if (item_ff.addr[15:13] == 3'b011) begin
               rsp_in.target        = TGT_PRG_RAM;
               rsp_in.target_offset = {5'd0, item_ff.addr[12:0]};
               rsp_in.writable      = 1'b1;
            end else if (item_ff.addr[15]) begin
               rsp_in.target        = TGT_PRG_ROM;
               rsp_in.target_offset = {wrapped[3:0], item_ff.addr[13:0]};
            end
         end
         OP_PPU_LOOKUP: begin
            if (item_ff.addr[15:13] == 3'b000) begin
               if (chr_ram_ff) begin
                  rsp_in.target        = TGT_CHR_RAM;
                  rsp_in.target_offset = {5'd0, item_ff.addr[12:0]};
                  rsp_in.writable      = 1'b1;
               end else begin
                  rsp_in.target        = TGT_CHR_ROM;
                  rsp_in.target_offset = {1'b0, wrapped, item_ff.addr[11:0]};
               end
            end
         end
         default: ;
      endcase
      rsp_in.nt_mirror = mirror_fin;
   end

   always_comb begin
      if (csr_we && (csr_index == CSR_INITIAL_MIRROR)) mirror_in = csr_data[1:0];
      else if (cmd.finish) mirror_in = mirror_fin;
      else mirror_in = mirror_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff   <= 5'd8;
         chr_count_ff   <= 6'd2;
         chr_ram_ff     <= 1'b0;
         step_ff        <= 8'd12;
         shift_bits_ff  <= 5'd0;
         shift_count_ff <= 3'd0;
         control_ff     <= 5'd0;
         prg_mode_ff    <= 2'd3;
         chr_mode_ff    <= 1'b0;
         chr_low_ff     <= 5'd0;
         chr_high_ff    <= 5'd0;
         prg_bank_ff    <= 4'd0;
         mirror_ff      <= 2'd3;
         last_cycle_ff  <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mirror_ff    <= mirror_in;
         rsp_valid_ff <= cmd.finish;
         if (csr_we) begin
            case (csr_index)
               CSR_PRG_BANK_COUNT:  prg_count_ff   <= csr_data[4:0];
               CSR_CHR_BANK_COUNT:  chr_count_ff   <= csr_data[5:0];
               CSR_CHR_RAM_PRESENT: chr_ram_ff     <= csr_data[0];
               // loads the live mirroring through mirror_in
               CSR_INITIAL_MIRROR:  ;
               CSR_CYCLE_STEP:      step_ff        <= csr_data;
               default: ;
            endcase
         end
         if (cmd.finish) begin
            shift_bits_ff  <= shift_bits_in;
            shift_count_ff <= shift_count_in;
            control_ff     <= control_in;
            prg_mode_ff    <= prg_mode_in;
            chr_mode_ff    <= chr_mode_in;
            chr_low_ff     <= chr_low_in;
            chr_high_ff    <= chr_high_in;
            prg_bank_ff    <= prg_bank_in;
            last_cycle_ff  <= last_cycle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SLBM_ASSERT_SAME(a_shift_count_range, clock, reset, 1'b1, shift_count_ff <= 3'd4,
      "shift count passed the commit point")
   `SLBM_ASSERT_NEXT(a_finish_strobes, clock, reset, cmd.finish, rsp_valid_ff,
      "finish without result strobe")
   `SLBM_ASSERT_SAME(a_chr_bank_wrapped, clock, reset,
      (rsp_valid_ff && (rsp_ff.target == TGT_CHR_ROM) && (chr_count_ff != 6'd0)),
      ({1'b0, rsp_ff.target_offset[16:12]} < chr_count_ff),
      "chr bank not wrapped below bank count")

endmodule

[rtl/core/serial_loaded_bank_mapper.sv]
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// cartridge bank mapper with a five-bit serial register port and address lookup
// ----------------------------------------------------------------------------
//  channel  ports                      beat taken when
//  req      start, busy, req_payload   start high and busy low
//  rsp      rsp_valid, rsp_payload     every cycle rsp_valid is high
//  csr      csr_valid, csr_ready,      csr_valid and csr_ready high
//           csr_index, csr_data
//
//  every item runs from accept to result strobe through prep, five steps
//  of the bit-serial remainder unit (bank wrap modulo bank count), a check
//  that sees the unit done, and update
//  the result strobe comes in the cycle after the update; busy is already low
//  then, so a new item can be taken in that cycle; no item is taken while busy
//  synchronous reset restores all mapper and csr registers, no clearing pass
//  the receiver cannot stall; csr writes are taken only while idle
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper
   import slbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_payload,
   // result out
   output logic                   rsp_valid,
   output rsp_type                rsp_payload,
   // csr write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       csr_we;

   // csr beats only between items
   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   // sequencer
   slbm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // registers, bank select, remainder unit, result register
   slbm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
